/* sv/srtf_tick_scheduler_top_macros.svh */
// Assertion macros shared by the scheduler RTL.
// Clock is clk and reset is rst in every module that uses them.
`ifndef SRTF_TICK_SCHEDULER_TOP_MACROS_SVH
`define SRTF_TICK_SCHEDULER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Check that is suspended while reset is high.
`define SRTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also covers the reset cycles.
`define SRTF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRTF_ASSERT(lbl, prop, msg)
`define SRTF_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* sv/srtf_pkg.sv */
// Shared constants, item codes and table port structs for the SRTF scheduler.
// No dependencies.
package srtf_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [23:0] MAX24 = 24'hFFFFFF;

  // Request from the sequencer to the slot table; all accesses but clear use idx.
  typedef struct packed {
    logic [SLOT_W-1:0] idx;
    logic              load;
    logic              clear;
    logic [7:0]        label;
    logic [15:0]       arrival;
    logic [15:0]       burst;
    logic              rem_we;
    logic [15:0]       rem_d;
    logic              wait_we;
    logic [23:0]       wait_d;
    logic              bump_we;
    logic              bump_d;
  } tbl_req_t;

  // Contents of the slot at idx.
  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  label;
    logic [23:0] wait_cnt;
    logic        bump;
  } tbl_rd_t;

endpackage

/* sv/srtf_slot_table.sv */
// Per-slot job storage: remaining time, arrival, burst, label, wait count, bump flag.
// Depends on srtf_pkg; a single index serves both read and write.
module srtf_slot_table (
  input  logic             clk,
  input  logic             rst,
  input  srtf_pkg::tbl_req_t req,
  output srtf_pkg::tbl_rd_t  rd
);
  import srtf_pkg::*;

  logic [15:0]      rem      [SLOTS];
  logic [15:0]      arrival  [SLOTS];
  logic [15:0]      burst    [SLOTS];
  logic [7:0]       label    [SLOTS];
  logic [23:0]      wait_cnt [SLOTS];
  logic [SLOTS-1:0] bump;

  // Remaining time alone marks a slot as occupied, so only it is cleared.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      for (int i = 0; i < SLOTS; i++) begin
        rem[i] <= 16'd0;
      end
    end else if (req.load) begin
      rem[req.idx] <= req.burst;
    end else if (req.rem_we) begin
      rem[req.idx] <= req.rem_d;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      arrival[req.idx]  <= req.arrival;
      burst[req.idx]    <= req.burst;
      label[req.idx]    <= req.label;
      wait_cnt[req.idx] <= 24'd0;
    end else if (req.wait_we) begin
      wait_cnt[req.idx] <= req.wait_d;
    end
    if (req.bump_we) begin
      bump[req.idx] <= req.bump_d;
    end
  end

  assign rd.rem      = rem[req.idx];
  assign rd.arrival  = arrival[req.idx];
  assign rd.burst    = burst[req.idx];
  assign rd.label    = label[req.idx];
  assign rd.wait_cnt = wait_cnt[req.idx];
  assign rd.bump     = bump[req.idx];

endmodule

/* sv/srtf_seq.sv */
// Sequencer with the shared compare/add unit: slot scan, retire step, result register.
// Depends on srtf_pkg and srtf_tick_scheduler_top_macros.svh; drives srtf_slot_table.
`include "srtf_tick_scheduler_top_macros.svh"

module srtf_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [2:0]         slot,
  input  logic [7:0]         job_label,
  input  logic [15:0]        arrival_tick,
  input  logic [15:0]        burst_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         ran_slot,
  output logic [7:0]         ran_label,
  output logic               idle,
  output logic               finished,
  output logic [23:0]        wait_total,
  output logic [23:0]        turnaround,
  output logic [23:0]        tick_now,
  output srtf_pkg::tbl_req_t req,
  input  srtf_pkg::tbl_rd_t  rd
);
  import srtf_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RETIRE = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  logic [1:0]        state;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] best;
  logic [15:0]       best_rem;
  logic              found;
  logic [23:0]       tick_count;

  logic [2:0]  res_slot;
  logic [7:0]  res_label;
  logic        res_idle;
  logic        res_fin;
  logic [23:0] res_wait;
  logic [23:0] res_turn;
  logic [23:0] res_tick;

  logic        accept;
  logic        slot_ok;
  logic        ready_c;
  logic        better;
  logic        bump_c;
  logic        fin_c;
  logic        emit_go;
  logic [23:0] wait_corr;
  logic [24:0] turn_sum;
  logic [23:0] turn_sat;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign slot_ok  = (7'(slot) < 7'(SLOTS));
  assign emit_go  = !out_valid || out_ready;

  // Shared compare unit: readiness and least-remaining test on the slot at idx.
  assign ready_c = (rd.rem != 16'd0) && ({8'd0, rd.arrival} <= tick_count);
  assign better  = ready_c && (!found || (rd.rem < best_rem));
  assign bump_c  = ready_c && (rd.wait_cnt != MAX24);

  // Retire arithmetic: undo the scan's bump on the chosen slot.
  assign wait_corr = rd.wait_cnt - {23'd0, rd.bump};
  assign turn_sum  = {1'b0, wait_corr} + {9'd0, rd.burst};
  assign turn_sat  = turn_sum[24] ? MAX24 : turn_sum[23:0];
  assign fin_c     = (rd.rem == 16'd1);

  always_comb begin
    req         = '0;
    req.label   = job_label;
    req.arrival = arrival_tick;
    req.burst   = burst_length;
    req.wait_d  = rd.wait_cnt + 24'd1;
    req.rem_d   = rd.rem - 16'd1;
    req.bump_d  = bump_c;
    case (state)
      S_IDLE: begin
        req.idx   = SLOT_W'(slot);
        req.load  = accept && (mode == MODE_LOAD) && slot_ok;
        req.clear = accept && (mode == MODE_CLEAR);
      end
      S_SCAN: begin
        // Bump every ready slot whose wait count is not saturated; the chosen one is undone at retire.
        req.idx     = idx;
        req.bump_we = 1'b1;
        req.wait_we = bump_c;
      end
      S_RETIRE: begin
        req.idx     = best;
        req.rem_we  = found;
        req.wait_we = found;
        req.wait_d  = wait_corr;
      end
      default: begin
        req.idx = idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      found      <= 1'b0;
      tick_count <= 24'd0;
      out_valid  <= 1'b0;
    end else begin
      // Load the result register or drop valid once the transfer is done.
      if (state == S_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (mode == MODE_TICK) begin
              state <= S_SCAN;
              idx   <= '0;
              found <= 1'b0;
            end else begin
              state <= S_EMIT;
            end
            if (mode == MODE_CLEAR) begin
              tick_count <= 24'd0;
            end
          end
        end
        S_SCAN: begin
          if (better) begin
            found <= 1'b1;
          end
          if (idx == LAST_IDX) begin
            state <= S_RETIRE;
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end
        S_RETIRE: begin
          state <= S_EMIT;
          if (tick_count != MAX24) begin
            tick_count <= tick_count + 24'd1;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_slot  <= 3'd0;
        res_label <= 8'd0;
        res_idle  <= 1'b1;
        res_fin   <= 1'b0;
        res_wait  <= 24'd0;
        res_turn  <= 24'd0;
        res_tick  <= (mode == MODE_CLEAR) ? 24'd0 : tick_count;
      end
      S_SCAN: begin
        if (better) begin
          best     <= idx;
          best_rem <= rd.rem;
        end
      end
      S_RETIRE: begin
        res_tick <= tick_count;
        if (found) begin
          res_slot  <= 3'(best);
          res_label <= rd.label;
          res_idle  <= 1'b0;
          res_fin   <= fin_c;
          res_wait  <= fin_c ? wait_corr : 24'd0;
          res_turn  <= fin_c ? turn_sat : 24'd0;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          ran_slot   <= res_slot;
          ran_label  <= res_label;
          idle       <= res_idle;
          finished   <= res_fin;
          wait_total <= res_wait;
          turnaround <= res_turn;
          tick_now   <= res_tick;
        end
      end
      default: begin
      end
    endcase
  end

  `SRTF_ASSERT_RST(a_rst_clean, rst |=> !out_valid && state == S_IDLE, "reset left work pending")
  `SRTF_ASSERT(a_retire_order, state == S_RETIRE |-> $past(state) == S_SCAN && $past(idx) == LAST_IDX, "retire before full scan")
  `SRTF_ASSERT(a_tick_adv, state == S_RETIRE |=> tick_count == (($past(tick_count) == MAX24) ? MAX24 : $past(tick_count) + 24'd1), "tick counter did not advance")
  `SRTF_ASSERT(a_best_live, state == S_RETIRE && found |-> best_rem != 16'd0 && rd.rem == best_rem, "chosen slot is empty or changed")
  `SRTF_ASSERT(a_idle_zero, out_valid && idle |-> !finished && wait_total == 24'd0 && turnaround == 24'd0, "idle result carries job data")

endmodule

/* sv/srtf_tick_scheduler_top.sv */
// Channel    | Dir | Handshake            | Payload
// input item | in  | in_valid / in_ready  | mode, slot, job_label, arrival_tick, burst_length
// result     | out | out_valid / out_ready| ran_slot, ran_label, idle, finished, wait_total,
//            |     |                      | turnaround, tick_now
// A tick item passes through the accept step, one compare step per slot in the scan,
// one retire step and one transfer into the result register. Load, clear and unused
// items go from the accept step straight to the transfer.
// Reset (rst, synchronous) empties all slots and zeroes the tick counter; no clearing pass.
// A stalled result holds the block in its emit step; the next item is taken once it moves.
// Depends on srtf_pkg, srtf_slot_table and srtf_seq.
module srtf_tick_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [2:0]  slot,
  input  logic [7:0]  job_label,
  input  logic [15:0] arrival_tick,
  input  logic [15:0] burst_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  ran_slot,
  output logic [7:0]  ran_label,
  output logic        idle,
  output logic        finished,
  output logic [23:0] wait_total,
  output logic [23:0] turnaround,
  output logic [23:0] tick_now
);
  import srtf_pkg::*;

  tbl_req_t req;
  tbl_rd_t  rd;

  srtf_slot_table u_table (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rd  (rd)
  );

  srtf_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .slot         (slot),
    .job_label    (job_label),
    .arrival_tick (arrival_tick),
    .burst_length (burst_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ran_slot     (ran_slot),
    .ran_label    (ran_label),
    .idle         (idle),
    .finished     (finished),
    .wait_total   (wait_total),
    .turnaround   (turnaround),
    .tick_now     (tick_now),
    .req          (req),
    .rd           (rd)
  );

endmodule
